FILE: rtl/rba_pkg.sv
// shared types, widths and operation codes of the block allocator
`timescale 1ns / 1ps

package rba_pkg;

   localparam int FUNC_W       = 3;
   localparam int BLOCK_ID_W   = 8;
   localparam int HASH_W       = 64;
   localparam int REF_COUNT_W  = 16;

   localparam int NUM_BLOCKS_DEF = 256;
   localparam int COUNT_BITS_DEF = 16;

   typedef logic [FUNC_W-1:0]      func_type;
   typedef logic [BLOCK_ID_W-1:0]  block_id_type;
   typedef logic [HASH_W-1:0]      hash_type;
   typedef logic [REF_COUNT_W-1:0] ref_count_type;

   localparam func_type FUNC_ALLOC    = 3'd0;
   localparam func_type FUNC_ADD_REF  = 3'd1;
   localparam func_type FUNC_RELEASE  = 3'd2;
   localparam func_type FUNC_SET_HASH = 3'd3;
   localparam func_type FUNC_QUERY    = 3'd4;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

FILE: rtl/rba_req_if.sv
// request channel interface
`timescale 1ns / 1ps

interface rba_req_if;
   logic                  valid;
   logic                  ready;
   rba_pkg::func_type     func;
   rba_pkg::block_id_type block_id;
   rba_pkg::hash_type     hash_value;

   modport source (output valid, func, block_id, hash_value, input ready);
   modport sink (input valid, func, block_id, hash_value, output ready);
endinterface

FILE: rtl/rba_rsp_if.sv
// response channel interface
`timescale 1ns / 1ps

interface rba_rsp_if;
   logic                   valid;
   logic                   ready;
   rba_pkg::block_id_type  granted_block;
   logic                   granted;
   rba_pkg::ref_count_type ref_count;
   rba_pkg::hash_type      hash_out;

   modport source (output valid, granted_block, granted, ref_count, hash_out, input ready);
   modport sink (input valid, granted_block, granted, ref_count, hash_out, output ready);
endinterface

FILE: rtl/rba_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rba_ctrl.sv
// request sequencing state machine and response valid
`timescale 1ns / 1ps

module rba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rba_pkg::cmd_type cmd
);
   import rba_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_EXEC) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = accept;
   assign cmd.execute = (state_ff == ST_EXEC);

endmodule

FILE: rtl/rba_datapath.sv
// free stack, count and hash tables, live bits and response register
`timescale 1ns / 1ps

module rba_datapath #(
   parameter int NUM_BLOCKS = rba_pkg::NUM_BLOCKS_DEF,
   parameter int COUNT_BITS = rba_pkg::COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rba_pkg::cmd_type       cmd,
   input  rba_pkg::func_type      req_func,
   input  rba_pkg::block_id_type  req_block_id,
   input  rba_pkg::hash_type      req_hash_value,
   output rba_pkg::block_id_type  rsp_granted_block,
   output logic                   rsp_granted,
   output rba_pkg::ref_count_type rsp_ref_count,
   output rba_pkg::hash_type      rsp_hash_out
);
   import rba_pkg::*;

   localparam int ID_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int LVL_W = $clog2(NUM_BLOCKS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [LVL_W-1:0]      LVL_FULL  = LVL_W'(NUM_BLOCKS);
   localparam logic [ID_W-1:0]       ID_LAST   = ID_W'(NUM_BLOCKS - 1);

   func_type              func_ff;
   block_id_type          id_ff;
   hash_type              hash_ff;

   logic [LVL_W-1:0]      level_ff;
   logic [LVL_W-1:0]      level_in;
   logic [LVL_W-1:0]      level_dec;
   logic [LVL_W-1:0]      low_ff;
   logic [LVL_W-1:0]      low_in;
   logic [NUM_BLOCKS-1:0] live_ff;
   logic [NUM_BLOCKS-1:0] live_in;

   block_id_type          granted_block_ff;
   logic                  granted_ff;
   ref_count_type         ref_count_ff;
   hash_type              hash_out_ff;

   logic [ID_W-1:0]       id_idx;
   logic [ID_W-1:0]       pop_idx;
   logic [ID_W-1:0]       pop_id;
   logic [ID_W-1:0]       stack_rd;
   logic                  stack_we;
   logic [ID_W-1:0]       stack_wa;
   logic [COUNT_BITS-1:0] cnt_rd;
   logic                  cnt_we;
   logic [ID_W-1:0]       cnt_wa;
   logic [COUNT_BITS-1:0] cnt_wd;
   hash_type              hash_rd;
   logic                  hash_we;
   logic [ID_W-1:0]       hash_wa;
   hash_type              hash_wd;

   logic                  id_ok;
   logic                  live;
   logic [COUNT_BITS-1:0] cnt_cur;
   hash_type              hash_cur;
   logic [COUNT_BITS-1:0] cnt_dec;
   logic [COUNT_BITS-1:0] new_cnt;
   hash_type              new_hash;
   block_id_type          new_gid;
   logic                  new_granted;
   logic [REF_COUNT_W+COUNT_BITS-1:0] cnt_ext;

   // slots below the lowest level ever reached are not read: their id is ID_LAST minus the slot
   assign id_idx    = id_ff[ID_W-1:0];
   assign level_dec = level_ff - LVL_W'(1);
   assign pop_idx   = level_dec[ID_W-1:0];
   assign pop_id    = (level_dec >= low_ff) ? stack_rd : (ID_LAST - pop_idx);
   assign id_ok     = ({1'b0, id_ff} < (BLOCK_ID_W + 1)'(NUM_BLOCKS));
   assign live      = id_ok && live_ff[id_idx];
   assign cnt_cur   = live ? cnt_rd : '0;
   assign hash_cur  = live ? hash_rd : '0;
   assign cnt_dec   = cnt_cur - COUNT_ONE;
   assign stack_wa  = level_ff[ID_W-1:0];

   rba_ram #(.WIDTH(ID_W), .DEPTH(NUM_BLOCKS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_wa),
      .wr_data (id_idx),
      .rd_addr (pop_idx),
      .rd_data (stack_rd)
   );

   rba_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BLOCKS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wa),
      .wr_data (cnt_wd),
      .rd_addr (req_block_id[ID_W-1:0]),
      .rd_data (cnt_rd)
   );

   rba_ram #(.WIDTH(HASH_W), .DEPTH(NUM_BLOCKS)) u_hash_ram (
      .clock   (clock),
      .wr_en   (hash_we),
      .wr_addr (hash_wa),
      .wr_data (hash_wd),
      .rd_addr (req_block_id[ID_W-1:0]),
      .rd_data (hash_rd)
   );

   always_comb begin
      level_in    = level_ff;
      low_in      = low_ff;
      live_in     = live_ff;
      stack_we    = 1'b0;
      cnt_we      = 1'b0;
      cnt_wa      = id_idx;
      cnt_wd      = cnt_cur;
      hash_we     = 1'b0;
      hash_wa     = id_idx;
      hash_wd     = hash_ff;
      new_cnt     = '0;
      new_hash    = '0;
      new_gid     = '0;
      new_granted = 1'b0;
      case (func_ff)
         FUNC_ALLOC: begin
            if (level_ff != '0) begin
               level_in        = level_dec;
               if (level_dec < low_ff) begin
                  low_in = level_dec;
               end
               cnt_we          = 1'b1;
               cnt_wa          = pop_id;
               cnt_wd          = COUNT_ONE;
               hash_we         = 1'b1;
               hash_wa         = pop_id;
               hash_wd         = '0;
               live_in[pop_id] = 1'b1;
               new_cnt         = COUNT_ONE;
               new_gid         = BLOCK_ID_W'(pop_id);
               new_granted     = 1'b1;
            end
         end
         FUNC_ADD_REF: begin
            new_cnt  = cnt_cur;
            new_hash = hash_cur;
            if (live && (cnt_cur != COUNT_MAX)) begin
               cnt_we  = 1'b1;
               cnt_wd  = cnt_cur + COUNT_ONE;
               new_cnt = cnt_cur + COUNT_ONE;
            end
         end
         FUNC_RELEASE: begin
            new_cnt  = cnt_cur;
            new_hash = hash_cur;
            if (live) begin
               cnt_we  = 1'b1;
               cnt_wd  = cnt_dec;
               new_cnt = cnt_dec;
               if (cnt_dec == '0) begin
                  live_in[id_idx] = 1'b0;
                  new_hash        = '0;
                  if (level_ff < LVL_FULL) begin
                     stack_we = 1'b1;
                     level_in = level_ff + LVL_W'(1);
                  end
               end
            end
         end
         FUNC_SET_HASH: begin
            new_cnt  = cnt_cur;
            new_hash = hash_cur;
            if (live) begin
               hash_we  = 1'b1;
               new_hash = hash_ff;
            end
         end
         FUNC_QUERY: begin
            new_cnt  = cnt_cur;
            new_hash = hash_cur;
         end
         default: begin
            new_cnt = '0;
         end
      endcase
      if (!cmd.execute) begin
         level_in = level_ff;
         low_in   = low_ff;
         live_in  = live_ff;
         stack_we = 1'b0;
         cnt_we   = 1'b0;
         hash_we  = 1'b0;
      end
   end

   assign cnt_ext = {{REF_COUNT_W{1'b0}}, new_cnt};

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LVL_FULL;
         low_ff   <= LVL_FULL;
         live_ff  <= '0;
      end else begin
         level_ff <= level_in;
         low_ff   <= low_in;
         live_ff  <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         id_ff   <= req_block_id;
         hash_ff <= req_hash_value;
      end
      if (cmd.execute) begin
         granted_block_ff <= new_gid;
         granted_ff       <= new_granted;
         ref_count_ff     <= cnt_ext[REF_COUNT_W-1:0];
         hash_out_ff      <= new_hash;
      end
   end

   assign rsp_granted_block = granted_block_ff;
   assign rsp_granted       = granted_ff;
   assign rsp_ref_count     = ref_count_ff;
   assign rsp_hash_out      = hash_out_ff;

endmodule

FILE: rtl/refcounted_block_allocator_top.sv
// Reference-counted block allocator with a LIFO free stack.
// Channels: req_bus carries one request beat (func, block_id, hash_value),
// rsp_bus returns exactly one response beat per request (granted_block,
// granted, ref_count, hash_out), both valid/ready, a beat moving on an edge
// where valid and ready are both high.
// Latency: the response is valid from the clock edge after the request beat.
// Pacing: a new request waits until the last has passed the registered
// read of the stack, count and hash RAMs and the read-modify-write step.
// Reset: synchronous, active high. Every block is free, the stack is full
// with id 0 on top; per-block live bits and a stack low-water mark
// replace any clearing pass, so requests are taken right after reset.
// Stall: a response held by rsp ready low stays stable in its output
// register; the next request is taken in the cycle the held response
// leaves, so no beat is lost or repeated.
`timescale 1ns / 1ps

module refcounted_block_allocator_top #(
   parameter int NUM_BLOCKS = rba_pkg::NUM_BLOCKS_DEF,
   parameter int COUNT_BITS = rba_pkg::COUNT_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   rba_req_if.sink   req_bus,
   rba_rsp_if.source rsp_bus
);
   import rba_pkg::*;

   cmd_type cmd;

   rba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   rba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_func          (req_bus.func),
      .req_block_id      (req_bus.block_id),
      .req_hash_value    (req_bus.hash_value),
      .rsp_granted_block (rsp_bus.granted_block),
      .rsp_granted       (rsp_bus.granted),
      .rsp_ref_count     (rsp_bus.ref_count),
      .rsp_hash_out      (rsp_bus.hash_out)
   );

endmodule
